@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is high
`define VFD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vfd assertion failed");

// next-cycle implication, off while reset is high
`define VFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vfd assertion failed");

// next-cycle implication, checked during reset as well
`define VFD_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("vfd assertion failed");

`endif

@@ rtl/vfd_pkg.sv @@
// Shared constants, types and codes for the vibrato fractional delay block.
// No dependencies.
package vfd_pkg;

   // data path sizes
   localparam int SAMPLE_BITS = 16;
   localparam int RING_DEPTH  = 1024;
   localparam int PTR_W       = $clog2(RING_DEPTH);
   localparam int PHASE_BITS  = 24;
   localparam int MAXD_BITS   = 10;
   localparam int FRAC_BITS   = 16;
   localparam int FRAC_SHIFT  = PHASE_BITS - 1 - FRAC_BITS;

   localparam logic [PHASE_BITS-1:0] HALF_PHASE = {1'b1, {(PHASE_BITS-1){1'b0}}};

   // shared multiplier operand and product widths
   localparam int MUL_A_W = ((PHASE_BITS > SAMPLE_BITS + 1) ? PHASE_BITS : SAMPLE_BITS + 1) + 1;
   localparam int MUL_B_W = ((PTR_W > FRAC_BITS) ? PTR_W : FRAC_BITS) + 1;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // interpolation accumulator
   localparam int ACC_W      = SAMPLE_BITS + FRAC_BITS + 2;
   localparam int ROUND_BIAS = 1 << (FRAC_BITS - 1);

   // configuration port
   localparam int CSR_W     = 24;
   localparam int CSR_IDX_W = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ENABLE      = 2'd0,
      CSR_MAX_DELAY   = 2'd1,
      CSR_PHASE_INC   = 2'd2,
      CSR_START_PHASE = 2'd3
   } csr_index_type;

   localparam logic                  ENABLE_RST      = 1'b0;
   localparam logic [MAXD_BITS-1:0]  MAX_DELAY_RST   = 10'd50;
   localparam logic [PHASE_BITS-1:0] PHASE_INC_RST   = 24'd350;
   localparam logic [PHASE_BITS-1:0] START_PHASE_RST = 24'd0;

   // sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MULD,
      ST_ADDR,
      ST_RD1,
      ST_MULF,
      ST_OUT
   } seq_state_type;

   // ring write port
   typedef struct packed {
      logic                          en;
      logic [PTR_W-1:0]              addr;
      logic signed [SAMPLE_BITS-1:0] data;
   } ring_wr_type;

endpackage

@@ rtl/vfd_req_if.sv @@
// Input sample channel: valid/ready handshake with one sample.
// Depends on vfd_pkg.
interface vfd_req_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [vfd_pkg::SAMPLE_BITS-1:0] sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

@@ rtl/vfd_rsp_if.sv @@
// Result sample channel: valid/ready handshake with one sample.
// Depends on vfd_pkg.
interface vfd_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [vfd_pkg::SAMPLE_BITS-1:0] sample_out;

   modport source (output valid, output sample_out, input ready);
   modport sink   (input valid, input sample_out, output ready);
endinterface

@@ rtl/vibrato_fractional_delay.sv @@
// Top level of the vibrato fractional delay: sequencer, registers, data path.
// Depends on vfd_pkg, vfd_req_if, vfd_rsp_if, vfd_ring and vfd_mult.
//
//   channel   direction  transfer when     payload
//   req_chan  in         valid & ready     sample_in  (signed Q1.15)
//   rsp_chan  out        valid & ready     sample_out (signed Q1.15)
//   csr_*     in         csr_we            csr_index, csr_wdata
//
// Enabled: samples are taken one at a time, each stepping through accept, delay
//   multiply, address, tap read, interpolation multiply and output load; the
//   single multiplier and single ring read port make this serial. Bypass: accept, output load.
// After reset the ring is cleared one entry a cycle, with req ready low until every
//   entry is cleared. Configuration writes are taken at any time.
// A stalled result holds in the output register; the next sample is taken
//   meanwhile and waits in the output-load step until the register frees.
module vibrato_fractional_delay (
   input  logic                              clock,
   input  logic                              reset,
   vfd_req_if.sink                           req_chan,
   vfd_rsp_if.source                         rsp_chan,
   input  logic                              csr_we,
   input  logic [vfd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [vfd_pkg::CSR_W-1:0]         csr_wdata
);

   localparam int PW = vfd_pkg::PTR_W;
   localparam int SB = vfd_pkg::SAMPLE_BITS;

   // sequencer
   vfd_pkg::seq_state_type state_ff, state_in;
   logic [PW-1:0]          clr_cnt_ff;

   // configuration
   logic                             enable_ff;
   logic [vfd_pkg::MAXD_BITS-1:0]    max_delay_ff;
   logic [vfd_pkg::PHASE_BITS-1:0]   phase_inc_ff;

   // persistent state
   logic [vfd_pkg::PHASE_BITS-1:0]   lfo_ff;
   logic [PW-1:0]                    wp_ff;

   // per-sample working registers
   logic signed [SB-1:0]             x_ff;
   logic                             bypass_ff;
   logic [vfd_pkg::PHASE_BITS-1:0]   d_ff;
   logic [vfd_pkg::FRAC_BITS-1:0]    frac_ff;
   logic [PW-1:0]                    r2_ff;
   logic signed [SB-1:0]             tap1_ff;

   // output register
   logic                             rsp_valid_ff;
   logic signed [SB-1:0]             rsp_data_ff;

   // datapath wires
   logic                             req_ready;
   logic                             accept;
   logic                             out_free;
   logic [PW-1:0]                    m_sat;
   logic [PW:0]                      n_len;
   logic [PW-1:0]                    wp_eff;
   logic [vfd_pkg::PHASE_BITS-1:0]   d_val;
   logic [PW-1:0]                    di;
   logic [PW:0]                      r1_sum;
   logic [PW-1:0]                    r1;
   logic [PW-1:0]                    r2;
   logic [PW:0]                      wp_inc;
   logic [PW-1:0]                    wp_next;
   logic signed [SB:0]               tap_diff;
   logic signed [vfd_pkg::ACC_W-1:0] acc;
   logic signed [SB-1:0]             interp;

   vfd_pkg::ring_wr_type                   ring_wr;
   logic [PW-1:0]                          rd_addr;
   logic signed [SB-1:0]                   rd_data;
   logic signed [vfd_pkg::MUL_A_W-1:0]     mul_a;
   logic signed [vfd_pkg::MUL_B_W-1:0]     mul_b;
   logic signed [vfd_pkg::MUL_P_W-1:0]     product;

   vfd_ring u_ring (
      .clock   (clock),
      .wr      (ring_wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   vfd_mult u_mult (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .product (product)
   );

   assign accept   = req_chan.valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // peak delay clipped to the ring, ring length and pointer restart
   always_comb begin
      if (32'(max_delay_ff) > 32'(vfd_pkg::RING_DEPTH - 1)) begin
         m_sat = PW'(vfd_pkg::RING_DEPTH - 1);
      end else begin
         m_sat = PW'(max_delay_ff);
      end
      n_len  = {1'b0, m_sat} + (PW+1)'(1);
      wp_eff = ({1'b0, wp_ff} >= n_len) ? '0 : wp_ff;
   end

   // triangle LFO magnitude |phase - 1/2|
   assign d_val = (lfo_ff >= vfd_pkg::HALF_PHASE) ? (lfo_ff - vfd_pkg::HALF_PHASE)
                                                  : (vfd_pkg::HALF_PHASE - lfo_ff);

   // tap addresses from the registered delay product
   always_comb begin
      di     = product[vfd_pkg::PHASE_BITS-1 +: PW];
      r1_sum = {1'b0, wp_ff} + (n_len - {1'b0, di});
      r1     = (r1_sum >= n_len) ? PW'(r1_sum - n_len) : PW'(r1_sum);
      r2     = (r1 == '0) ? m_sat : (r1 - PW'(1));
   end

   assign wp_inc  = {1'b0, wp_ff} + (PW+1)'(1);
   assign wp_next = (wp_inc == n_len) ? '0 : wp_inc[PW-1:0];

   // tap2 - tap1, tap2 straight from the ring read register
   assign tap_diff = {rd_data[SB-1], rd_data} - {tap1_ff[SB-1], tap1_ff};

   // tap1 * 2^16 + (tap2 - tap1) * f, rounded to nearest
   assign acc = vfd_pkg::ACC_W'($signed({tap1_ff, {vfd_pkg::FRAC_BITS{1'b0}}}))
              + $signed(product[vfd_pkg::ACC_W-1:0])
              + vfd_pkg::ACC_W'(vfd_pkg::ROUND_BIAS);
   assign interp = acc[vfd_pkg::FRAC_BITS +: SB];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         vfd_pkg::ST_CLEAR: begin
            if (clr_cnt_ff == PW'(vfd_pkg::RING_DEPTH - 1)) begin
               state_in = vfd_pkg::ST_IDLE;
            end
         end
         vfd_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = enable_ff ? vfd_pkg::ST_MULD : vfd_pkg::ST_OUT;
            end
         end
         vfd_pkg::ST_MULD: state_in = vfd_pkg::ST_ADDR;
         vfd_pkg::ST_ADDR: state_in = vfd_pkg::ST_RD1;
         vfd_pkg::ST_RD1:  state_in = vfd_pkg::ST_MULF;
         vfd_pkg::ST_MULF: state_in = vfd_pkg::ST_OUT;
         vfd_pkg::ST_OUT: begin
            if (out_free) begin
               state_in = vfd_pkg::ST_IDLE;
            end
         end
         default: state_in = vfd_pkg::ST_CLEAR;
      endcase
   end

   // sequencer outputs: ring ports, multiplier operands, ready
   always_comb begin
      req_ready    = 1'b0;
      ring_wr.en   = 1'b0;
      ring_wr.addr = wp_eff;
      ring_wr.data = req_chan.sample_in;
      rd_addr      = '0;
      mul_a        = '0;
      mul_b        = '0;
      case (state_ff)
         vfd_pkg::ST_CLEAR: begin
            ring_wr.en   = 1'b1;
            ring_wr.addr = clr_cnt_ff;
            ring_wr.data = '0;
         end
         vfd_pkg::ST_IDLE: begin
            req_ready  = 1'b1;
            ring_wr.en = accept && enable_ff;
         end
         vfd_pkg::ST_MULD: begin
            mul_a = $signed({{(vfd_pkg::MUL_A_W - vfd_pkg::PHASE_BITS){1'b0}}, d_ff});
            mul_b = $signed({{(vfd_pkg::MUL_B_W - PW){1'b0}}, m_sat});
         end
         vfd_pkg::ST_ADDR: rd_addr = r1;
         vfd_pkg::ST_RD1:  rd_addr = r2_ff;
         // tap2 read and operands held while the result waits: product stays put
         vfd_pkg::ST_MULF, vfd_pkg::ST_OUT: begin
            rd_addr = r2_ff;
            mul_a   = vfd_pkg::MUL_A_W'(tap_diff);
            mul_b   = $signed({{(vfd_pkg::MUL_B_W - vfd_pkg::FRAC_BITS){1'b0}}, frac_ff});
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vfd_pkg::ST_CLEAR;
         clr_cnt_ff   <= '0;
         enable_ff    <= vfd_pkg::ENABLE_RST;
         max_delay_ff <= vfd_pkg::MAX_DELAY_RST;
         phase_inc_ff <= vfd_pkg::PHASE_INC_RST;
         lfo_ff       <= vfd_pkg::START_PHASE_RST;
         wp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == vfd_pkg::ST_CLEAR) begin
            clr_cnt_ff <= clr_cnt_ff + PW'(1);
         end
         // pointer restart is kept, as is the advance at output time
         if (accept && enable_ff) begin
            wp_ff <= wp_eff;
         end
         if (state_ff == vfd_pkg::ST_OUT && out_free && !bypass_ff) begin
            wp_ff  <= wp_next;
            lfo_ff <= lfo_ff + phase_inc_ff;
         end
         if (csr_we) begin
            case (vfd_pkg::csr_index_type'(csr_index))
               vfd_pkg::CSR_ENABLE:      enable_ff    <= csr_wdata[0];
               vfd_pkg::CSR_MAX_DELAY:   max_delay_ff <= csr_wdata[vfd_pkg::MAXD_BITS-1:0];
               vfd_pkg::CSR_PHASE_INC:   phase_inc_ff <= csr_wdata[vfd_pkg::PHASE_BITS-1:0];
               vfd_pkg::CSR_START_PHASE: lfo_ff       <= csr_wdata[vfd_pkg::PHASE_BITS-1:0];
               default: begin
               end
            endcase
         end
         if (state_ff == vfd_pkg::ST_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff      <= req_chan.sample_in;
         bypass_ff <= !enable_ff;
         d_ff      <= d_val;
      end
      if (state_ff == vfd_pkg::ST_ADDR) begin
         frac_ff <= product[vfd_pkg::FRAC_SHIFT +: vfd_pkg::FRAC_BITS];
         r2_ff   <= r2;
      end
      if (state_ff == vfd_pkg::ST_RD1) begin
         tap1_ff <= rd_data;
      end
      if (state_ff == vfd_pkg::ST_OUT && out_free) begin
         rsp_data_ff <= bypass_ff ? x_ff : interp;
      end
   end

   assign req_chan.ready      = req_ready;
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.sample_out = rsp_data_ff;

endmodule

@@ rtl/vfd_ring.sv @@
// Delay line memory: one write port, one read port with registered data.
// Depends on vfd_pkg.
module vfd_ring (
   input  logic                                   clock,
   input  vfd_pkg::ring_wr_type                   wr,
   input  logic [vfd_pkg::PTR_W-1:0]              rd_addr,
   output logic signed [vfd_pkg::SAMPLE_BITS-1:0] rd_data
);

   logic signed [vfd_pkg::SAMPLE_BITS-1:0] ring_ff [vfd_pkg::RING_DEPTH];
   logic signed [vfd_pkg::SAMPLE_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         ring_ff[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= ring_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/vfd_mult.sv @@
// Shared signed multiplier with a registered product.
// Depends on vfd_pkg.
module vfd_mult (
   input  logic                                 clock,
   input  logic signed [vfd_pkg::MUL_A_W-1:0]   mul_a,
   input  logic signed [vfd_pkg::MUL_B_W-1:0]   mul_b,
   output logic signed [vfd_pkg::MUL_P_W-1:0]   product
);

   logic signed [vfd_pkg::MUL_P_W-1:0] product_ff;
   logic signed [vfd_pkg::MUL_P_W-1:0] product_in;

   assign product_in = vfd_pkg::MUL_P_W'(mul_a) * vfd_pkg::MUL_P_W'(mul_b);

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

@@ rtl/vfd_checker.sv @@
// Port-level checker for vibrato_fractional_delay, attached by bind.
// Depends on vfd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module vfd_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_valid,
   input logic                                   req_ready,
   input logic                                   rsp_valid,
   input logic                                   rsp_ready,
   input logic signed [vfd_pkg::SAMPLE_BITS-1:0] rsp_sample
);

   // a stalled result holds
   `VFD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_sample))

   // one sample in work at a time
   `VFD_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)

   // a new result appears only as the sequencer returns to idle
   `VFD_ASSERT_SAME(a_result_at_idle, clock, reset, $rose(rsp_valid), req_ready)

   // reset starts the clearing pass with nothing pending
   `VFD_ASSERT_NEXT_ALWAYS(a_reset_quiet, clock, reset, !req_ready && !rsp_valid)

endmodule

bind vibrato_fractional_delay vfd_checker u_vfd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_sample (rsp_chan.sample_out)
);
